@@ rtl/adpcm_4bit_encoder_unit_defines.svh @@
// Assertion macros shared by the ADPCM encoder RTL.
// Each expects signals named clock and reset in the including scope.
`ifndef ADPCM_4BIT_ENCODER_UNIT_DEFINES_SVH
`define ADPCM_4BIT_ENCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge outside reset.
`define ADPCM4_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("ADPCM encoder assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define ADPCM4_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ADPCM encoder assertion failed");
`else
`define ADPCM4_ASSERT(lbl, prop)
`define ADPCM4_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/adpcm4_pkg.sv @@
// Shared types, constants and the step scale table of the ADPCM encoder.
// No dependencies; every RTL module of the encoder imports it.
package adpcm4_pkg;

   localparam int PcmW   = 16;
   localparam int StepW  = 15;
   localparam int MagW   = 16;
   localparam int QW     = 3;
   localparam int NibW   = 4;
   localparam int ByteW  = 8;
   localparam int ScaleW = 8;
   localparam int DeltaW = 16;
   localparam int NstepW = 16;

   localparam logic [StepW-1:0] StepMin = 15'd127;
   localparam logic [StepW-1:0] StepMax = 15'd24576;
   localparam logic [QW-1:0]    CodeMax = 3'd7;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_QUANT,
      ST_MULT,
      ST_UPDATE
   } enc_state_type;

   // Products of the decoder update, held until the next multiply starts.
   typedef struct packed {
      logic [DeltaW-1:0] delta;      // ((1 + 2m) * step) >> 3
      logic [NstepW-1:0] nstep_raw;  // (scale[m] * step) >> 6, before clamping
   } mul_result_type;

   // Step multiplier table, in 64ths.
   function automatic logic [ScaleW-1:0] step_scale(input logic [QW-1:0] m);
      logic [ScaleW-1:0] s;
      unique case (m)
         3'd4:    s = 8'd77;
         3'd5:    s = 8'd102;
         3'd6:    s = 8'd128;
         3'd7:    s = 8'd153;
         default: s = 8'd57;
      endcase
      return s;
   endfunction

endpackage

@@ rtl/adpcm4_quant.sv @@
// Bit-serial quantizer: min(floor(4*mag/step), 7), one quotient bit per cycle.
// Depends on adpcm4_pkg.
module adpcm4_quant (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [adpcm4_pkg::MagW-1:0]   mag,
   input  logic [adpcm4_pkg::StepW-1:0]  step,
   output logic                          done,
   output logic [adpcm4_pkg::QW-1:0]     q
);
   import adpcm4_pkg::*;

   localparam int RemW = MagW + 2;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [1:0]      cnt_ff, cnt_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [RemW-1:0] div_ff, div_in;
   logic [QW-1:0]   q_ff, q_in;
   logic            ge;

   always_comb begin
      ge      = rem_ff >= div_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      q_in    = q_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = 2'd0;
         rem_in  = {mag, 2'b00};
         div_in  = {step, 3'b000};
         q_in    = '0;
      end else if (busy_ff) begin
         if (cnt_ff == 2'd0) begin
            // A quotient of eight or more saturates the code.
            if (ge) begin
               q_in    = CodeMax;
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               div_in = div_ff >> 1;
               cnt_in = 2'd1;
            end
         end else begin
            q_in   = {q_ff[QW-2:0], ge};
            div_in = div_ff >> 1;
            if (ge) begin
               rem_in = rem_ff - div_ff;
            end
            if (cnt_ff == 2'd3) begin
               busy_in = 1'b0;
               done_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign q    = q_ff;

endmodule

@@ rtl/adpcm4_mul.sv @@
// Bit-serial shift-add multiplier forming the prediction delta and the raw next
// step from the current step and the code magnitude. Depends on adpcm4_pkg.
module adpcm4_mul (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [adpcm4_pkg::StepW-1:0]      step,
   input  logic [adpcm4_pkg::QW-1:0]         m,
   output logic                              done,
   output adpcm4_pkg::mul_result_type        result
);
   import adpcm4_pkg::*;

   localparam int AccsW = StepW + ScaleW - 1;  // 153 * 24576 fits in 22 bits
   localparam int AccoW = StepW + NibW;        // 15 * 24576 fits in 19 bits
   localparam int OddW  = QW + 1;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [AccsW-1:0] mcand_ff, mcand_in;
   logic [ScaleW-1:0] sc_ff, sc_in;
   logic [OddW-1:0]  od_ff, od_in;
   logic [AccsW-1:0] accs_ff, accs_in;
   logic [AccoW-1:0] acco_ff, acco_in;

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      mcand_in = mcand_ff;
      sc_in    = sc_ff;
      od_in    = od_ff;
      accs_in  = accs_ff;
      acco_in  = acco_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = 3'd0;
         mcand_in = {{(AccsW-StepW){1'b0}}, step};
         sc_in    = step_scale(m);
         od_in    = {m, 1'b1};
         accs_in  = '0;
         acco_in  = '0;
      end else if (busy_ff) begin
         if (sc_ff[0]) begin
            accs_in = accs_ff + mcand_ff;
         end
         if (od_ff[0]) begin
            acco_in = acco_ff + mcand_ff[AccoW-1:0];
         end
         mcand_in = mcand_ff << 1;
         sc_in    = sc_ff >> 1;
         od_in    = od_ff >> 1;
         if (cnt_ff == 3'd7) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      mcand_ff <= mcand_in;
      sc_ff    <= sc_in;
      od_ff    <= od_in;
      accs_ff  <= accs_in;
      acco_ff  <= acco_in;
   end

   assign done             = done_ff;
   assign result.delta     = acco_ff[AccoW-1:3];
   assign result.nstep_raw = accs_ff[AccsW-1:6];

endmodule

@@ rtl/adpcm_4bit_encoder_unit.sv @@
// 4-bit ADPCM-B style encoder top level: handshakes, sequencer, state, packing.
// Depends on adpcm4_pkg, adpcm4_quant, adpcm4_mul and the assertion macro header.
`include "adpcm_4bit_encoder_unit_defines.svh"

// This encoder takes one signed 16-bit PCM sample per transfer on the req_
// channel and emits one byte of two packed 4-bit codes on the rsp_ channel for
// every second sample, the first sample's code in the high nibble. A sample
// transferred with req_tlast high ends the block: its byte goes out at once
// with rsp_tlast high (a lone code is padded with a zero low nibble) and the
// predictor and step size return to their reset values. One sample is worked
// on at a time, from its transfer until the block is ready again: the
// difference is formed at the transfer, the bit-serial quantizer finds the
// code (one quotient bit per cycle, stopping early when the code saturates
// at seven), the code is handed to the multiplier, the shift-add multiplier
// forms the prediction delta and the next step size, the sequencer sees the
// multiplier finish, and the update cycle follows.
// The result byte sits in an output register, so a new sample is taken while
// a byte still waits; only when a finished byte meets an earlier one not yet
// taken does the update cycle wait for rsp_tready.
module adpcm_4bit_encoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [15:0] pcm_sample (signed)
   input  logic        req_tlast,   // end_of_block
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] code_byte
   output logic        rsp_tlast    // final_byte
);
   import adpcm4_pkg::*;

   enc_state_type      state_ff, state_in;
   logic signed [PcmW-1:0] pred_ff, pred_in;
   logic [StepW-1:0]   step_ff, step_in;
   logic [NibW-1:0]    hi_nib_ff, hi_nib_in;
   logic               phase_ff, phase_in;
   logic               sign_ff, sign_in;
   logic               last_ff, last_in;
   logic [NibW-1:0]    code_ff, code_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [ByteW-1:0]   rsp_data_ff, rsp_data_in;
   logic               rsp_last_ff, rsp_last_in;

   logic               accept;
   logic [PcmW-1:0]    masked;
   logic signed [PcmW:0] diff;
   logic [PcmW:0]      mag_full;
   logic [MagW-1:0]    mag;
   logic               q_done;
   logic [QW-1:0]      q_val;
   logic               mul_start;
   logic               mul_done;
   mul_result_type     mul_res;
   logic               produce;
   logic               commit;
   logic signed [PcmW+1:0] pred_sum;
   logic signed [PcmW-1:0] pred_sat;
   logic [StepW-1:0]   step_next;

   // Difference of the masked sample and the prediction, taken at the transfer.
   always_comb begin
      masked   = {req_tdata[PcmW-1:3], 3'b000};
      diff     = $signed({masked[PcmW-1], masked}) - $signed({pred_ff[PcmW-1], pred_ff});
      mag_full = diff[PcmW] ? ((PcmW+1)'(0) - diff) : diff;
      mag      = mag_full[MagW-1:0];
   end

   adpcm4_quant u_quant (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .mag   (mag),
      .step  (step_ff),
      .done  (q_done),
      .q     (q_val)
   );

   adpcm4_mul u_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .step   (step_ff),
      .m      (q_val),
      .done   (mul_done),
      .result (mul_res)
   );

   // Prediction update with 16-bit saturation and the clamped next step.
   always_comb begin
      if (code_ff[NibW-1]) begin
         pred_sum = $signed({{2{pred_ff[PcmW-1]}}, pred_ff}) - $signed({2'b00, mul_res.delta});
      end else begin
         pred_sum = $signed({{2{pred_ff[PcmW-1]}}, pred_ff}) + $signed({2'b00, mul_res.delta});
      end
      priority if (pred_sum > $signed(18'sd32767)) begin
         pred_sat = 16'sh7FFF;
      end else if (pred_sum < $signed(-18'sd32768)) begin
         pred_sat = 16'sh8000;
      end else begin
         pred_sat = pred_sum[PcmW-1:0];
      end
      priority if (mul_res.nstep_raw < NstepW'(StepMin)) begin
         step_next = StepMin;
      end else if (mul_res.nstep_raw > NstepW'(StepMax)) begin
         step_next = StepMax;
      end else begin
         step_next = mul_res.nstep_raw[StepW-1:0];
      end
   end

   // Sequencer: idle, quantize, multiply, update.
   always_comb begin
      state_in     = state_ff;
      pred_in      = pred_ff;
      step_in      = step_ff;
      hi_nib_in    = hi_nib_ff;
      phase_in     = phase_ff;
      sign_in      = sign_ff;
      last_in      = last_ff;
      code_in      = code_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      req_tready   = 1'b0;
      mul_start    = 1'b0;
      produce      = phase_ff | last_ff;
      commit       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               sign_in  = diff[PcmW];
               last_in  = req_tlast;
               state_in = ST_QUANT;
            end
         end
         ST_QUANT: begin
            if (q_done) begin
               code_in   = {sign_ff, q_val};
               mul_start = 1'b1;
               state_in  = ST_MULT;
            end
         end
         ST_MULT: begin
            if (mul_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            // A finished byte may not overwrite one that is still waiting.
            if (!(produce && rsp_valid_ff && !rsp_tready)) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
               if (produce) begin
                  rsp_data_in = phase_ff ? {hi_nib_ff, code_ff} : {code_ff, 4'b0000};
                  rsp_last_in = last_ff;
               end
               if (last_ff) begin
                  pred_in   = '0;
                  step_in   = StepMin;
                  hi_nib_in = '0;
                  phase_in  = 1'b0;
               end else begin
                  pred_in   = pred_sat;
                  step_in   = step_next;
                  phase_in  = ~phase_ff;
                  if (!phase_ff) begin
                     hi_nib_in = code_ff;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      accept       = req_tvalid & req_tready;
      rsp_valid_in = (rsp_valid_ff & ~rsp_tready) | (commit & produce);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pred_ff      <= '0;
         step_ff      <= StepMin;
         hi_nib_ff    <= '0;
         phase_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pred_ff      <= pred_in;
         step_ff      <= step_in;
         hi_nib_ff    <= hi_nib_in;
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      sign_ff     <= sign_in;
      last_ff     <= last_in;
      code_ff     <= code_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // The step size never leaves its clamp range.
   `ADPCM4_ASSERT(a_step_range, step_ff >= StepMin && step_ff <= StepMax)
   // Only one sample is in work: a transfer closes the input side next cycle.
   `ADPCM4_ASSERT_NEXT(a_one_in_flight, accept, !req_tready)
   // A new result byte appears only out of the update cycle.
   `ADPCM4_ASSERT(a_rsp_from_update, !$rose(rsp_tvalid) || $past(state_ff == ST_UPDATE))
   // The quantizer finishes only while the sequencer waits for it.
   `ADPCM4_ASSERT(a_quant_in_step, !q_done || state_ff == ST_QUANT)

endmodule
